// ----- hw/rtl/psc_pkg.sv -----
// Shared types, register indexes and widths for the speed PID controller.
`timescale 1ns / 1ps

package psc_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DELTA_W = 18;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef logic [SPEED_W-1:0]        speed_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef enum logic [2:0] {
    REG_KP_GAIN    = 3'd0,
    REG_KI_GAIN    = 3'd1,
    REG_KD_GAIN    = 3'd2,
    REG_UPPER      = 3'd3,
    REG_LOWER      = 3'd4,
    REG_SEP_THRESH = 3'd5
  } reg_idx_t;

  localparam gain_t  KP_RESET     = 16'd3917;
  localparam gain_t  KI_RESET     = 16'd845;
  localparam gain_t  KD_RESET     = 16'd1050;
  localparam speed_t UPPER_RESET  = 16'd70;
  localparam speed_t LOWER_RESET  = 16'd10;
  localparam speed_t THRESH_RESET = 16'd80;

  typedef struct packed {
    gain_t  kp_gain;
    gain_t  ki_gain;
    gain_t  kd_gain;
    speed_t upper_limit;
    speed_t lower_limit;
    speed_t separation_threshold;
  } cfg_t;

  typedef struct packed {
    logic   valid;
    err_t   err;
    delta_t delta;
    acc_t   error_sum;
    logic   use_int;
  } err_stage_t;

endpackage

// ----- hw/rtl/psc_ifs.sv -----
// Valid/ready channel interfaces for samples and controller results.
`timescale 1ns / 1ps

interface psc_in_if
  import psc_pkg::*;
  ();
  logic   valid;
  logic   ready;
  speed_t setpoint;
  speed_t measured_speed;

  modport source (output valid, output setpoint, output measured_speed, input ready);
  modport sink (input valid, input setpoint, input measured_speed, output ready);
endinterface

interface psc_out_if
  import psc_pkg::*;
  ();
  logic   valid;
  logic   ready;
  drive_t drive;
  logic   integral_used;

  modport source (output valid, output drive, output integral_used, input ready);
  modport sink (input valid, input drive, input integral_used, output ready);
endinterface

// ----- hw/rtl/psc_cfg_regs.sv -----
// APB-style configuration register file for gains, limits and threshold.
`timescale 1ns / 1ps

module psc_cfg_regs
  import psc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;
  logic [GAIN_W-1:0] wdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wdata  = pwdata[GAIN_W-1:0];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_KP_GAIN:    cfg_nxt.kp_gain              = wdata;
        REG_KI_GAIN:    cfg_nxt.ki_gain              = wdata;
        REG_KD_GAIN:    cfg_nxt.kd_gain              = wdata;
        REG_UPPER:      cfg_nxt.upper_limit          = wdata;
        REG_LOWER:      cfg_nxt.lower_limit          = wdata;
        REG_SEP_THRESH: cfg_nxt.separation_threshold = wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_KP_GAIN:    prdata[GAIN_W-1:0] = cfg_r.kp_gain;
      REG_KI_GAIN:    prdata[GAIN_W-1:0] = cfg_r.ki_gain;
      REG_KD_GAIN:    prdata[GAIN_W-1:0] = cfg_r.kd_gain;
      REG_UPPER:      prdata[GAIN_W-1:0] = cfg_r.upper_limit;
      REG_LOWER:      prdata[GAIN_W-1:0] = cfg_r.lower_limit;
      REG_SEP_THRESH: prdata[GAIN_W-1:0] = cfg_r.separation_threshold;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain              <= KP_RESET;
      cfg_r.ki_gain              <= KI_RESET;
      cfg_r.kd_gain              <= KD_RESET;
      cfg_r.upper_limit          <= UPPER_RESET;
      cfg_r.lower_limit          <= LOWER_RESET;
      cfg_r.separation_threshold <= THRESH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/psc_integrator.sv -----
// Input register, error forming and saturating anti-windup integrator.
`timescale 1ns / 1ps

module psc_integrator
  import psc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  speed_t     setpoint,
  input  speed_t     measured_speed,
  input  cfg_t       cfg,
  output err_stage_t stage
);

  logic   s0_valid_r;
  speed_t sp_r;
  speed_t ms_r;

  acc_t   error_sum_r;
  acc_t   error_sum_nxt;
  err_t   prev_err_r;

  err_t   err;
  logic [SPEED_W-1:0] mag;
  logic   use_int;
  logic   add;
  logic signed [ACC_W:0] sum_wide;
  logic   step;

  err_stage_t stage_r;
  err_stage_t stage_nxt;

  assign step = s0_valid_r && adv;
  assign err  = $signed({1'b0, sp_r}) - $signed({1'b0, ms_r});
  assign mag  = err[ERR_W-1] ? SPEED_W'(-err) : err[SPEED_W-1:0];
  assign use_int = (mag <= cfg.separation_threshold);

  always_comb begin
    priority if (ms_r > cfg.upper_limit) begin
      add = err[ERR_W-1];
    end else if (ms_r < cfg.lower_limit) begin
      add = !err[ERR_W-1] && (err != '0);
    end else begin
      add = 1'b1;
    end
  end

  assign sum_wide = {error_sum_r[ACC_W-1], error_sum_r}
                  + {{(ACC_W+1-ERR_W){err[ERR_W-1]}}, err};

  always_comb begin
    error_sum_nxt = error_sum_r;
    if (use_int && add) begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
        error_sum_nxt = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        error_sum_nxt = sum_wide[ACC_W-1:0];
      end
    end
  end

  always_comb begin
    stage_nxt.valid     = s0_valid_r;
    stage_nxt.err       = err;
    stage_nxt.delta     = DELTA_W'(err) - DELTA_W'(prev_err_r);
    stage_nxt.error_sum = error_sum_nxt;
    stage_nxt.use_int   = use_int;
  end

  assign stage = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      stage_r.valid <= 1'b0;
      error_sum_r   <= '0;
      prev_err_r    <= '0;
    end else if (adv) begin
      s0_valid_r        <= in_valid;
      stage_r.valid     <= stage_nxt.valid;
      stage_r.err       <= stage_nxt.err;
      stage_r.delta     <= stage_nxt.delta;
      stage_r.error_sum <= stage_nxt.error_sum;
      stage_r.use_int   <= stage_nxt.use_int;
      if (step) begin
        error_sum_r <= error_sum_nxt;
        prev_err_r  <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r <= setpoint;
      ms_r <= measured_speed;
    end
  end

  a_sum_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(error_sum_r) && $stable(prev_err_r))
    else $error("integrator state changed without a request");

  a_sum_holds_when_separated: assert property (@(posedge clk) disable iff (!rst_n)
    step && !use_int |=> error_sum_r == $past(error_sum_r))
    else $error("separated request changed the integrator");

  a_prev_err_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> prev_err_r == $past(err) && stage_r.error_sum == error_sum_r)
    else $error("previous error or stage sum out of step");

endmodule

// ----- hw/rtl/psc_mac.sv -----
// Gain multiplies, sum and output saturation with the result register.
`timescale 1ns / 1ps

module psc_mac
  import psc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  err_stage_t stage,
  input  cfg_t       cfg,
  output logic       out_valid,
  output drive_t     drive,
  output logic       integral_used
);

  localparam int unsigned PP_W  = GAIN_W + 1 + ERR_W;
  localparam int unsigned PD_W  = GAIN_W + 1 + DELTA_W;
  localparam int unsigned PI_W  = GAIN_W + 1 + ACC_W;
  localparam int unsigned SUM_W = PI_W + 2;

  logic signed [PP_W-1:0] pp_nxt;
  logic signed [PD_W-1:0] pd_nxt;
  logic signed [PI_W-1:0] pi_nxt;
  logic signed [PP_W-1:0] pp_r;
  logic signed [PD_W-1:0] pd_r;
  logic signed [PI_W-1:0] pi_r;
  logic                   p_valid_r;
  logic                   p_use_r;

  logic signed [SUM_W-1:0] sum;
  drive_t                  drive_nxt;
  logic                    out_valid_r;
  drive_t                  drive_r;
  logic                    used_r;

  assign pp_nxt = $signed({1'b0, cfg.kp_gain}) * stage.err;
  assign pd_nxt = $signed({1'b0, cfg.kd_gain}) * stage.delta;

  always_comb begin
    if (stage.use_int) begin
      pi_nxt = $signed({1'b0, cfg.ki_gain}) * stage.error_sum;
    end else begin
      pi_nxt = '0;
    end
  end

  assign sum = SUM_W'(pp_r) + SUM_W'(pd_r) + SUM_W'(pi_r);

  always_comb begin
    if (sum[SUM_W-1:DRIVE_W-1] == '0 || sum[SUM_W-1:DRIVE_W-1] == '1) begin
      drive_nxt = sum[DRIVE_W-1:0];
    end else begin
      drive_nxt = sum[SUM_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                               : {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  assign out_valid     = out_valid_r;
  assign drive         = drive_r;
  assign integral_used = used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r   <= stage.valid;
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_r    <= pp_nxt;
      pd_r    <= pd_nxt;
      pi_r    <= pi_nxt;
      p_use_r <= stage.use_int;
      drive_r <= drive_nxt;
      used_r  <= p_use_r;
    end
  end

endmodule

// ----- hw/rtl/pid_speed_controller_antiwindup.sv -----
// Top level of the speed PID controller with integral separation and anti-windup.
`timescale 1ns / 1ps

// Takes one speed sample (setpoint, measured speed) per cycle and returns one
// result per sample: the saturated Q24.8 drive and a flag that tells whether the
// integral term was used. A request accepted into the input register passes
// through the integrator stage, the multiply stage and the result register that
// follow it before its result is offered; the pipeline stalls as a whole only
// while a finished result waits at the output. Gains, limits and the
// separation threshold are written over the APB port and should change only
// while no request is in flight.
module pid_speed_controller_antiwindup
  import psc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  psc_in_if.sink            in_chan,
  psc_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  err_stage_t stage;
  logic       adv;
  logic       out_valid;

  assign adv           = !out_valid || out_chan.ready;
  assign in_chan.ready = adv;
  assign out_chan.valid = out_valid;

  psc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psc_integrator u_int (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_chan.valid),
    .setpoint       (in_chan.setpoint),
    .measured_speed (in_chan.measured_speed),
    .cfg            (cfg),
    .stage          (stage)
  );

  psc_mac u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .stage         (stage),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .drive         (out_chan.drive),
    .integral_used (out_chan.integral_used)
  );

endmodule
